// ===== hdl/dssm_pkg.sv =====
`timescale 1ns / 1ps

package dssm_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int CFG_W      = 2;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_STACKS_ENABLED = 2'd0;
    localparam logic [CFG_W-1:0]   STACKS_ENABLED_RST  = 2'd2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] SEL_LOW  = 2'd1;
    localparam logic [1:0] SEL_HIGH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic emit_now;
        logic emit_read;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic pop_ok;
    } t_dp_sts;

endpackage

// ===== hdl/dual_stack_shared_memory_core.sv =====
`timescale 1ns / 1ps

// Two LIFO stacks in one shared RAM: stack 1 grows up from entry 0, stack 2
// grows down from the last entry. A request is taken when start is high and
// busy is low; it then holds the block busy in an execute state, followed
// for a successful pop by a read state for the registered read of the
// single-port RAM. The result appears on o_pop_value and o_status for exactly
// one cycle with o_valid high, in the cycle after the last busy cycle, and
// must be captured then: there is no backpressure. stacks_enabled must be
// written over the APB port while the block is idle; it is not enforced.

module dual_stack_shared_memory_core import dssm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [1:0]         i_stack_sel,
    input  logic [WORD_W-1:0]  i_push_value,
    output logic               o_valid,
    output logic [WORD_W-1:0]  o_pop_value,
    output logic [1:0]         o_status
);

    logic [CFG_W-1:0] r_stacks_enabled;
    logic             w_cfg_wr;
    logic             w_start;
    t_dp_ctl          w_ctl;
    t_dp_sts          w_sts;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_STACKS_ENABLED);
    assign prdata   = (paddr == ADDR_STACKS_ENABLED)
                    ? {{(PDATA_W - CFG_W){1'b0}}, r_stacks_enabled} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks_enabled <= STACKS_ENABLED_RST;
        end else if (w_cfg_wr) begin
            r_stacks_enabled <= pwdata[CFG_W-1:0];
        end
    end

    assign w_start = start && !busy;

    dssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // values 2 and 3 enable stack 2
    dssm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_stack2_en  (r_stacks_enabled[1]),
        .i_cmd        (i_cmd),
        .i_stack_sel  (i_stack_sel),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

endmodule

// ===== hdl/dssm_ram.sv =====
`timescale 1ns / 1ps

module dssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dssm_datapath.sv =====
`timescale 1ns / 1ps

module dssm_datapath import dssm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctl           i_ctl,
    output t_dp_sts           o_sts,
    input  logic              i_stack2_en,
    input  logic              i_cmd,
    input  logic [1:0]        i_stack_sel,
    input  logic [WORD_W-1:0] i_push_value,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_pop_value,
    output logic [1:0]        o_status
);

    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W:0]    FULL_SUM = (CNT_W + 1)'(DEPTH);

    logic              r_cmd;
    logic [1:0]        r_sel;
    logic [WORD_W-1:0] r_value;
    logic [CNT_W-1:0]  r_low_cnt,  n_low_cnt;
    logic [CNT_W-1:0]  r_high_cnt, n_high_cnt;
    logic              r_valid;
    logic [WORD_W-1:0] r_pop_value;
    logic [1:0]        r_status;

    logic                  w_sel_ok;
    logic [CNT_W:0]        w_sum;
    logic [1:0]            w_status;
    logic                  w_ok;
    logic [ADDR_W-1:0]     w_addr;
    logic                  w_we;
    logic                  w_re;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic signed [63:0]    w_push_ext;
    logic signed [63:0]    w_pop_ext;

    assign w_sel_ok = (r_sel == SEL_LOW) || ((r_sel == SEL_HIGH) && i_stack2_en);
    assign w_sum    = {1'b0, r_low_cnt} + {1'b0, r_high_cnt};

    always_comb begin
        if (!w_sel_ok) begin
            w_status = ST_INVALID;
        end else if (r_cmd == CMD_PUSH) begin
            w_status = (w_sum >= FULL_SUM) ? ST_FULL : ST_OK;
        end else if (r_sel == SEL_LOW) begin
            w_status = (r_low_cnt == '0) ? ST_EMPTY : ST_OK;
        end else begin
            w_status = (r_high_cnt == '0) ? ST_EMPTY : ST_OK;
        end
    end

    assign w_ok = (w_status == ST_OK);

    // low stack grows up from entry 0, high stack down from the top entry
    always_comb begin
        case ({r_cmd, r_sel == SEL_LOW})
            {CMD_PUSH, 1'b1}: w_addr = r_low_cnt[ADDR_W-1:0];
            {CMD_PUSH, 1'b0}: w_addr = TOP_ADDR - r_high_cnt[ADDR_W-1:0];
            {CMD_POP, 1'b1}:  w_addr = r_low_cnt[ADDR_W-1:0] - ADDR_W'(1);
            default:          w_addr = TOP_ADDR - r_high_cnt[ADDR_W-1:0] + ADDR_W'(1);
        endcase
    end

    assign w_we       = i_ctl.exec && w_ok && (r_cmd == CMD_PUSH);
    assign w_re       = i_ctl.exec && w_ok && (r_cmd == CMD_POP);
    assign w_push_ext = 64'(signed'(r_value));
    assign w_wdata    = w_push_ext[DATA_WIDTH-1:0];
    assign w_pop_ext  = 64'(signed'(w_rdata));

    assign o_sts.pop_ok = w_ok && (r_cmd == CMD_POP);

    always_comb begin
        n_low_cnt  = r_low_cnt;
        n_high_cnt = r_high_cnt;
        if (i_ctl.exec && w_ok) begin
            if (r_sel == SEL_LOW) begin
                n_low_cnt = (r_cmd == CMD_PUSH) ? r_low_cnt + CNT_W'(1)
                                                : r_low_cnt - CNT_W'(1);
            end else begin
                n_high_cnt = (r_cmd == CMD_PUSH) ? r_high_cnt + CNT_W'(1)
                                                 : r_high_cnt - CNT_W'(1);
            end
        end
    end

    dssm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_sel   <= i_stack_sel;
            r_value <= i_push_value;
        end
        if (i_ctl.emit_now) begin
            r_pop_value <= '0;
            r_status    <= w_status;
        end else if (i_ctl.emit_read) begin
            r_pop_value <= w_pop_ext[WORD_W-1:0];
            r_status    <= ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
            r_valid    <= i_ctl.emit_now || i_ctl.emit_read;
        end
    end

    assign o_valid     = r_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

endmodule

// ===== hdl/dssm_ctrl.sv =====
`timescale 1ns / 1ps

module dssm_ctrl import dssm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_ctl.load      = 1'b0;
        o_ctl.exec      = 1'b0;
        o_ctl.emit_now  = 1'b0;
        o_ctl.emit_read = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                // a successful pop goes on to the read state for the ram read
                if (i_sts.pop_ok) begin
                    n_state = S_READ;
                end else begin
                    o_ctl.emit_now = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                o_ctl.emit_read = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/dssm_checker.sv =====
`timescale 1ns / 1ps

module dssm_checker import dssm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [WORD_W-1:0] o_pop_value,
    input logic [1:0]        o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) && !busy)
        else $error("result strobe without a request in flight");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_pop_value == '0))
        else $error("nonzero pop value on a failed request");

endmodule

bind dual_stack_shared_memory_core dssm_checker u_dssm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_pop_value (o_pop_value),
    .o_status    (o_status)
);
